// File: hw/rtl/lbc_pkg.sv
// shared types and constants for the lru block cache controller
`timescale 1ns / 1ps
`default_nettype none
package lbc_pkg;

	localparam int unsigned CAPACITY_DEF = 8;
	localparam int unsigned TAG_W        = 24;
	localparam int unsigned SLOT_W       = 3;
	// widest slot index over the supported capacity range
	localparam int unsigned IDX_MAX_W    = 6;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [1:0] ST_HIT     = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_INSERT  = 2'd2;
	localparam logic [1:0] ST_PRESENT = 2'd3;

	typedef struct packed {
		logic             opcode;
		logic [TAG_W-1:0] block_id;
		logic             dirty_in;
	} req_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic              writeback;
		logic              evicted_valid;
		logic [TAG_W-1:0]  evicted_block;
	} rsp_item_t;

	typedef struct packed {
		logic                 touch;
		logic                 insert;
		logic                 evict;
		logic [IDX_MAX_W-1:0] slot;
		logic                 dirty;
	} entry_upd_t;

endpackage
`default_nettype wire

// File: hw/rtl/lbc_tag_ram.sv
// block number store, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module lbc_tag_ram import lbc_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [TAG_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [TAG_W-1:0] rd_data
);

	logic [TAG_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/lbc_entry_state.sv
// per-entry valid, dirty and age rank flops with touch and insert updates
`timescale 1ns / 1ps
`default_nettype none
module lbc_entry_state import lbc_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire entry_upd_t                       upd,
	output logic      [CAPACITY-1:0]              valid_q,
	output logic      [CAPACITY-1:0]              dirty_q,
	output logic      [CAPACITY-1:0][IDX_W-1:0]   rank_q,
	output logic      [CNT_W-1:0]                 count_q
);

	logic [IDX_W-1:0] sel;
	logic [IDX_W-1:0] sel_rank;

	assign sel      = upd.slot[IDX_W-1:0];
	assign sel_rank = rank_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			rank_q  <= '0;
			count_q <= '0;
		end else if (upd.insert) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDX_W'(i) == sel) begin
					valid_q[i] <= 1'b1;
					dirty_q[i] <= upd.dirty;
					rank_q[i]  <= '0;
				end else if (valid_q[i]) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
			// an eviction frees the slot it refills, so the count holds
			if (!upd.evict) begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (upd.touch) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDX_W'(i) == sel) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && rank_q[i] < sel_rank) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count disagrees with valid bits");

	a_insert_most_recent: assert property (@(posedge clk) disable iff (!arst_n)
		upd.insert |=> valid_q[$past(sel)] && rank_q[$past(sel)] == '0)
		else $error("inserted entry not valid and most recent");

endmodule
`default_nettype wire

// File: hw/rtl/lru_block_cache_controller_core.sv
// top level: request sequencer, tag scan and result register
//
// Fully associative block cache directory with least-recently-used
// replacement. Each request walks all CAPACITY slots through a single
// tag read port, one slot per cycle, with one shared comparator that
// checks the tag match and the replacement candidate of each slot. A
// request is accepted in S_IDLE, scans every slot in S_SCAN, passes
// S_DRAIN and waits in S_DONE, where the result waits for rsp_ready
// while the previous result is held, before the next request is taken.
// Most of this sequence is the scan over the tag store's one read port. The
// slot output carries the low three bits of the slot index.
`timescale 1ns / 1ps
`default_nettype none
module lru_block_cache_controller_core import lbc_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	req_item_t  req_q;
	logic [IDX_W-1:0] idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_slot_q;
	logic             vic_found_q;
	logic [IDX_W-1:0] vic_slot_q;
	logic [TAG_W-1:0] vic_tag_q;
	logic             vic_dirty_q;
	logic             full_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic [CAPACITY-1:0]            valid_q;
	logic [CAPACITY-1:0]            dirty_q;
	logic [CAPACITY-1:0][IDX_W-1:0] rank_q;
	logic [CNT_W-1:0]               count_q;
	logic [TAG_W-1:0]               rd_data;

	logic       rd_en;
	logic       out_free;
	logic       finish;
	logic       do_insert;
	logic       is_match;
	logic       is_cand;
	entry_upd_t upd;
	rsp_item_t  rsp_next;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_en     = (state_q == S_SCAN);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign finish    = (state_q == S_DONE) && out_free;
	assign do_insert = (req_q.opcode == OP_INSERT) && !hit_q;

	// shared compare unit: tag match and replacement candidate of one slot
	always_comb begin
		is_match = valid_q[cmp_idx_s1] && (rd_data == req_q.block_id);
		if (full_q) begin
			is_cand = valid_q[cmp_idx_s1] &&
				(CNT_W'(rank_q[cmp_idx_s1]) == count_q - CNT_W'(1));
		end else begin
			is_cand = !valid_q[cmp_idx_s1];
		end
	end

	always_comb begin
		upd        = '0;
		upd.slot   = IDX_MAX_W'(do_insert ? vic_slot_q : hit_slot_q);
		upd.dirty  = req_q.dirty_in;
		upd.evict  = full_q;
		upd.insert = finish && do_insert;
		upd.touch  = finish && (req_q.opcode == OP_LOOKUP) && hit_q;

		rsp_next = '0;
		case ({req_q.opcode, hit_q})
			{OP_LOOKUP, 1'b1}: begin
				rsp_next.status = ST_HIT;
				rsp_next.slot   = SLOT_W'(hit_slot_q);
			end
			{OP_LOOKUP, 1'b0}: begin
				rsp_next.status = ST_MISS;
			end
			{OP_INSERT, 1'b1}: begin
				rsp_next.status = ST_PRESENT;
				rsp_next.slot   = SLOT_W'(hit_slot_q);
			end
			default: begin
				rsp_next.status        = ST_INSERT;
				rsp_next.slot          = SLOT_W'(vic_slot_q);
				rsp_next.evicted_valid = full_q;
				rsp_next.writeback     = full_q && vic_dirty_q;
				rsp_next.evicted_block = full_q ? vic_tag_q : '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			hit_q       <= 1'b0;
			hit_slot_q  <= '0;
			vic_found_q <= 1'b0;
			vic_slot_q  <= '0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1  <= (state_q == S_SCAN);
			rsp_valid_q <= finish || (rsp_valid_q && !rsp_ready);
			if (cmp_vld_s1) begin
				if (is_match && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= cmp_idx_s1;
				end
				if (is_cand && !vic_found_q) begin
					vic_found_q <= 1'b1;
					vic_slot_q  <= cmp_idx_s1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q       <= '0;
						hit_q       <= 1'b0;
						hit_slot_q  <= '0;
						vic_found_q <= 1'b0;
						vic_slot_q  <= '0;
						full_q      <= (count_q == CNT_W'(CAPACITY));
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_idx_s1 <= idx_q;
					if (idx_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (cmp_vld_s1 && is_cand && !vic_found_q) begin
			vic_tag_q   <= rd_data;
			vic_dirty_q <= dirty_q[cmp_idx_s1];
		end
		if (finish) begin
			rsp_q <= rsp_next;
		end
	end

	lbc_tag_ram #(
		.CAPACITY (CAPACITY)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (upd.insert),
		.wr_addr (vic_slot_q),
		.wr_data (req_q.block_id),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	lbc_entry_state #(
		.CAPACITY (CAPACITY)
	) u_entry_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.valid_q (valid_q),
		.dirty_q (dirty_q),
		.rank_q  (rank_q),
		.count_q (count_q)
	);

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !cmp_vld_s1 && !upd.insert && !upd.touch)
		else $error("request taken while a scan or update is under way");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(upd.insert && upd.touch))
		else $error("touch and insert in the same cycle");

	a_result_follows_done: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp_valid && state_q == S_IDLE)
		else $error("finished item did not reach the result register");

endmodule
`default_nettype wire
